>>> hw/rtl/stg_pkg.sv
// Package: shared constants, register indexes and the quarter-wave sine table for the tone generator.
package stg_pkg;

  // Table geometry
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int unsigned QUARTER_LEN    = 1 << QUARTER_BITS;
  localparam int unsigned QIDX_BITS      = QUARTER_BITS + 1;
  localparam int unsigned AMP_BITS       = 7;

  // Field and register widths
  localparam int unsigned STEP_BITS   = 32;
  localparam int unsigned VOL_BITS    = 9;
  localparam int unsigned SAMPLE_BITS = 8;
  localparam int unsigned MAG_BITS    = 8;
  localparam int unsigned CFG_IDX_BITS = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME     = 1'b1;

  // Reset values and output levels
  localparam logic [STEP_BITS-1:0]   PHASE_STEP_RST = 32'd40904454;
  localparam logic [VOL_BITS-1:0]    VOLUME_RST     = 9'd26;
  localparam logic [SAMPLE_BITS-1:0] SILENCE_LEVEL  = 8'd127;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX     = 8'd254;

  // Q30 constants for the table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic [AMP_BITS-1:0] qtab_t [QUARTER_LEN+1];

  // round(127 * sin(x)) with x in Q30, Taylor series up to the x^13 term
  function automatic logic [AMP_BITS-1:0] sine127(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] v;
    x2   = (x * x) >> 30;
    pos  = x;
    neg  = 64'd0;
    term = (x * x2) >> 30;
    term = term / 64'd6;
    neg  = neg + term;
    term = (term * x2) >> 30;
    term = term / 64'd20;
    pos  = pos + term;
    term = (term * x2) >> 30;
    term = term / 64'd42;
    neg  = neg + term;
    term = (term * x2) >> 30;
    term = term / 64'd72;
    pos  = pos + term;
    term = (term * x2) >> 30;
    term = term / 64'd110;
    neg  = neg + term;
    term = (term * x2) >> 30;
    term = term / 64'd156;
    pos  = pos + term;
    s = (pos > neg) ? (pos - neg) : 64'd0;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    v = (s * 64'd127 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd127) begin
      v = 64'd127;
    end
    return v[AMP_BITS-1:0];
  endfunction

  // Build the quarter wave, both ends included
  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      tab[k] = sine127((HALF_PI_Q30 * 64'(k)) >> QUARTER_BITS);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

>>> hw/rtl/sine_tone_generator_unit.sv
// Top level: phase accumulator, two-stage sample pipeline and configuration registers.
// An accepted transaction passes through the stage-one register and the result register to out_*.
// Throughput: one sample per cycle; the phase add sits in the first stage and the
// table lookup with the gain multiply in the second. A stalled result holds both stages.
// Reset: phase clears to zero, phase_step returns to PHASE_STEP_RST and volume to 26/256,
// and both pipeline stages empty.
module sine_tone_generator_unit
  import stg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_playing,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  out_sample,
  // Configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [STEP_BITS-1:0]    cfg_data
);

  logic [STEP_BITS-1:0]      phase_step_r;
  logic [VOL_BITS-1:0]       volume_r;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [PHASE_BITS-1:0]     phase_nxt;
  logic [PHASE_BITS-1:0]     step_ext;
  logic                      s1_valid_r;
  logic                      s1_play_r;
  logic [SINE_ADDR_BITS-1:0] s1_addr_r;
  logic                      out_valid_r;
  logic [SAMPLE_BITS-1:0]    out_sample_r;
  logic [SAMPLE_BITS-1:0]    sample_nxt;
  logic                      out_en;
  logic                      s1_en;
  logic                      in_acc;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      volume_r     <= VOLUME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_data;
        REG_VOLUME:     volume_r     <= cfg_data[VOL_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Pipeline flow control: a stage advances when the one after it can take its contents
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign in_acc   = in_valid && s1_en;

  // Advance the phase accumulator
  assign step_ext  = PHASE_BITS'(phase_step_r);
  assign phase_nxt = phase_r + step_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_acc && in_playing) begin
      phase_r <= phase_nxt;
    end
  end

  // Stage one: hold the table address of the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_play_r <= in_playing;
      s1_addr_r <= phase_nxt[PHASE_BITS-1 -: SINE_ADDR_BITS];
    end
  end

  stg_shape u_shape (
    .playing (s1_play_r),
    .addr    (s1_addr_r),
    .volume  (volume_r),
    .sample  (sample_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Phase holds across a silent transaction
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_playing |=> phase_r == $past(phase_r))
    else $error("phase moved on a silent transaction");

  // Phase advances by the tuning word on a playing transaction
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_playing |=> phase_r == $past(phase_r) + $past(step_ext))
    else $error("phase did not advance by the tuning word");

  // A silent transaction leaving stage one yields the silence level
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_play_r && out_en |=> out_sample == SILENCE_LEVEL)
    else $error("silent transaction gave a non-silence sample");

  // Input stalls only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // Samples stay within the DAC range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample <= SAMPLE_MAX)
    else $error("sample above the DAC range");

endmodule

>>> hw/rtl/stg_shape.sv
// Sine shaper: quadrant folding, quarter-wave lookup, volume scaling and offset to a DAC code.
module stg_shape
  import stg_pkg::*;
(
  input  logic                      playing,
  input  logic [SINE_ADDR_BITS-1:0] addr,
  input  logic [VOL_BITS-1:0]       volume,
  output logic [SAMPLE_BITS-1:0]    sample
);

  logic [1:0]                    quad;
  logic [QUARTER_BITS-1:0]       j_raw;
  logic [QIDX_BITS-1:0]          j_idx;
  logic [AMP_BITS-1:0]           amp;
  logic [AMP_BITS+VOL_BITS-1:0]  prod;
  logic [MAG_BITS-1:0]           mag;
  logic [SAMPLE_BITS:0]          up_sum;
  logic [SAMPLE_BITS-1:0]        tone;

  // Fold the phase into the first quadrant
  assign quad  = addr[SINE_ADDR_BITS-1 -: 2];
  assign j_raw = addr[QUARTER_BITS-1:0];
  assign j_idx = quad[0] ? (QIDX_BITS'(QUARTER_LEN) - {1'b0, j_raw}) : {1'b0, j_raw};

  // Look up and scale by the Q1.8 gain
  assign amp  = QTAB[j_idx];
  assign prod = (AMP_BITS+VOL_BITS)'(amp) * (AMP_BITS+VOL_BITS)'(volume);
  assign mag  = prod[8 +: MAG_BITS];

  // Offset around midscale and saturate
  assign up_sum = (SAMPLE_BITS+1)'(SILENCE_LEVEL) + (SAMPLE_BITS+1)'(mag);

  always_comb begin
    if (quad[1]) begin
      tone = (mag > SILENCE_LEVEL) ? '0 : (SILENCE_LEVEL - mag);
    end else begin
      tone = (up_sum > (SAMPLE_BITS+1)'(SAMPLE_MAX)) ? SAMPLE_MAX : up_sum[SAMPLE_BITS-1:0];
    end
  end

  assign sample = playing ? tone : SILENCE_LEVEL;

endmodule
